// ===== rtl/core/mdsc_pkg.sv =====
// Shared types and constants for the microprogrammed datapath core.
`default_nettype none
package mdsc_pkg;
    localparam int MemBytes  = 65536;
    localparam int MemAw     = $clog2(MemBytes);
    localparam int CsDepth   = 512;
    localparam int CsAw      = $clog2(CsDepth);
    localparam int MiW       = 36;

    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_MEMW = 2'd1;
    localparam logic [1:0] OP_CSW  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [3:0] B_MDR  = 4'd0;
    localparam logic [3:0] B_PC   = 4'd1;
    localparam logic [3:0] B_MBRU = 4'd2;
    localparam logic [3:0] B_MBRS = 4'd3;
    localparam logic [3:0] B_SP   = 4'd4;
    localparam logic [3:0] B_LV   = 4'd5;
    localparam logic [3:0] B_CPP  = 4'd6;
    localparam logic [3:0] B_TOS  = 4'd7;
    localparam logic [3:0] B_OPC  = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_UIR, S_EXEC, S_FETCH,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RDLAST,
        S_WR0, S_WR1, S_WR2, S_WR3, S_DONE
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic       clr_step;   // write zero at clear address
        logic       mem_load;   // byte load request
        logic       cs_load;    // control store load
        logic       cs_read;    // read microinstruction
        logic       exec;       // ALU/shift/C-bus and latch memory ctl
        logic       fetch_rd;   // issue fetch read
        logic       fetch_cap;  // capture MBR
        logic       rd_issue;   // issue word byte read
        logic       rd_cap;     // capture byte into MDR
        logic [1:0] rd_idx;     // byte index issued
        logic [1:0] cap_idx;    // byte index captured
        logic       wr_byte;    // write word byte
        logic [1:0] wr_idx;
        logic       npc;        // form next micro-PC
        logic       rst_state;  // reset architectural state
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic do_fetch;
        logic do_read;
        logic do_write;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/core/mdsc_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module mdsc_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/mdsc_ctrl.sv =====
// Sequencer FSM for loads, clearing pass and microcycle phases.
`default_nettype none
module mdsc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [1:0]     i_opcode,
    input  wire mdsc_pkg::t_stat i_stat,
    output mdsc_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    import mdsc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_opcode == OP_EXEC) ? S_UIR : S_DONE;
                end
            end
            S_CLEAR:  if (i_stat.clr_done) n_state = S_IDLE;
            S_UIR:    n_state = S_EXEC;
            S_EXEC:   n_state = S_FETCH;
            S_FETCH:  n_state = i_stat.do_read ? S_RD0 : (i_stat.do_write ? S_WR0 : S_DONE);
            S_RD0:    n_state = S_RD1;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_RD3;
            S_RD3:    n_state = S_RDLAST;
            S_RDLAST: n_state = i_stat.do_write ? S_WR0 : S_DONE;
            S_WR0:    n_state = S_WR1;
            S_WR1:    n_state = S_WR2;
            S_WR2:    n_state = S_WR3;
            S_WR3:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.mem_load = i_start && (i_opcode == OP_MEMW);
                o_cmd.cs_load  = i_start && (i_opcode == OP_CSW);
                o_cmd.cs_read  = i_start && (i_opcode == OP_EXEC);
            end
            S_CLEAR: begin
                o_cmd.clr_step  = 1'b1;
                o_cmd.rst_state = 1'b1;
            end
            S_UIR:  o_cmd.exec = 1'b1;
            S_EXEC: o_cmd.fetch_rd = 1'b1;
            S_FETCH: begin
                o_cmd.fetch_cap = 1'b1;
                // MBR is final here, so the next micro-PC can be formed now
                o_cmd.npc       = 1'b1;
                o_cmd.rd_issue  = i_stat.do_read;
                o_cmd.rd_idx    = 2'd0;
            end
            S_RD0: begin
                o_cmd.rd_issue = 1'b1; o_cmd.rd_idx = 2'd1;
                o_cmd.rd_cap = 1'b1;   o_cmd.cap_idx = 2'd0;
            end
            S_RD1: begin
                o_cmd.rd_issue = 1'b1; o_cmd.rd_idx = 2'd2;
                o_cmd.rd_cap = 1'b1;   o_cmd.cap_idx = 2'd1;
            end
            S_RD2: begin
                o_cmd.rd_issue = 1'b1; o_cmd.rd_idx = 2'd3;
                o_cmd.rd_cap = 1'b1;   o_cmd.cap_idx = 2'd2;
            end
            S_RD3: begin
                o_cmd.rd_cap = 1'b1;   o_cmd.cap_idx = 2'd3;
            end
            S_RDLAST: ;
            S_WR0: begin o_cmd.wr_byte = 1'b1; o_cmd.wr_idx = 2'd0; end
            S_WR1: begin o_cmd.wr_byte = 1'b1; o_cmd.wr_idx = 2'd1; end
            S_WR2: begin o_cmd.wr_byte = 1'b1; o_cmd.wr_idx = 2'd2; end
            S_WR3: begin o_cmd.wr_byte = 1'b1; o_cmd.wr_idx = 2'd3; end
            S_DONE: o_done = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/mdsc_dp.sv =====
// Datapath: registers, ALU, shifter, control store and byte memory.
`default_nettype none
module mdsc_dp (
    input  wire logic            i_clk,
    input  wire mdsc_pkg::t_cmd  i_cmd,
    input  wire logic [15:0]     i_load_address,
    input  wire logic [35:0]     i_load_data,
    output mdsc_pkg::t_stat      o_stat,
    output logic [8:0]           o_micro_pc,
    output logic [31:0]          o_mar, o_mdr, o_pc, o_sp, o_lv, o_cpp, o_tos, o_opc, o_h,
    output logic [7:0]           o_mbr,
    output logic [1:0]           o_flags
);
    import mdsc_pkg::*;

    logic [31:0] r_mar, r_mdr, r_pc, r_sp, r_lv, r_cpp, r_tos, r_opc, r_h;
    logic [7:0]  r_mbr;
    logic [8:0]  r_mpc;
    logic        r_n, r_z;
    logic [2:0]  r_memctl;
    logic [2:0]  r_jam;
    logic [8:0]  r_nxt;
    logic [MemAw:0] r_clr;

    // Control store
    logic [MiW-1:0] cs_rdata;
    logic [CsAw-1:0] cs_addr;
    assign cs_addr = i_cmd.cs_load ? i_load_address[CsAw-1:0] : r_mpc[CsAw-1:0];
    mdsc_ram #(.Width(MiW), .Depth(CsDepth)) u_cs (
        .i_clk(i_clk), .i_we(i_cmd.cs_load), .i_addr(cs_addr),
        .i_wdata(i_load_data), .o_rdata(cs_rdata)
    );

    // Byte memory
    logic [MemAw-1:0] m_addr, word_base;
    logic [7:0] m_wdata, m_rdata;
    logic m_we;
    assign word_base = {r_mar[MemAw-3:0], 2'b00};
    always_comb begin
        m_we = 1'b0; m_wdata = '0; m_addr = r_pc[MemAw-1:0];
        if (i_cmd.clr_step) begin
            m_we = 1'b1; m_addr = r_clr[MemAw-1:0];
        end else if (i_cmd.mem_load) begin
            m_we = 1'b1; m_addr = i_load_address[MemAw-1:0]; m_wdata = i_load_data[7:0];
        end else if (i_cmd.rd_issue) begin
            m_addr = word_base + MemAw'(i_cmd.rd_idx);
        end else if (i_cmd.wr_byte) begin
            m_we = 1'b1; m_addr = word_base + MemAw'(i_cmd.wr_idx);
            m_wdata = r_mdr[8*i_cmd.wr_idx +: 8];
        end
    end
    mdsc_ram #(.Width(8), .Depth(MemBytes)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    // MBR as it stands once this step's fetch lands
    logic [7:0] mbr_now;
    assign mbr_now = (i_cmd.fetch_cap && r_memctl[0]) ? m_rdata : r_mbr;

    // Microinstruction fields
    logic [3:0] bsel; logic [8:0] cmask; logic [5:0] fn; logic [1:0] sh;
    assign bsel  = cs_rdata[3:0];
    assign cmask = cs_rdata[15:7];
    assign fn    = cs_rdata[21:16];
    assign sh    = cs_rdata[23:22];

    logic [31:0] bbus, xa, yb, aout, cbus;
    always_comb begin
        case (bsel)
            B_MDR:  bbus = r_mdr;
            B_PC:   bbus = r_pc;
            B_MBRU: bbus = {24'd0, r_mbr};
            B_MBRS: bbus = {{24{r_mbr[7]}}, r_mbr};
            B_SP:   bbus = r_sp;
            B_LV:   bbus = r_lv;
            B_CPP:  bbus = r_cpp;
            B_TOS:  bbus = r_tos;
            B_OPC:  bbus = r_opc;
            default: bbus = '0;
        endcase
        xa = fn[3] ? r_h : '0;
        if (fn[1]) xa = ~xa;
        yb = fn[2] ? bbus : '0;
        case ({fn[5], fn[4]})
            2'b00:   aout = xa & yb;
            2'b01:   aout = xa | yb;
            2'b10:   aout = ~yb;
            default: aout = xa + yb + {31'd0, fn[0]};
        endcase
        cbus = sh[0] ? {aout[23:0], 8'd0} : aout;
        if (sh[1]) cbus = {cbus[31], cbus[31:1]};
    end

    assign o_stat.clr_done = r_clr[MemAw];
    assign o_stat.do_fetch = r_memctl[0];
    assign o_stat.do_read  = r_memctl[1];
    assign o_stat.do_write = r_memctl[2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rst_state) begin
            r_mar <= '0; r_mdr <= '0; r_pc <= '0; r_sp <= '0; r_lv <= '0;
            r_cpp <= '0; r_tos <= '0; r_opc <= '0; r_h <= '0;
            r_mbr <= '0; r_mpc <= '0; r_n <= 1'b0; r_z <= 1'b1;
            r_memctl <= '0;
            r_clr <= r_clr + 1'b1;
        end else begin
            r_clr <= '0;
            if (i_cmd.exec) begin
                r_n <= aout[31];
                r_z <= (aout == '0);
                if (cmask[0]) r_mar <= cbus;
                if (cmask[1]) r_mdr <= cbus;
                if (cmask[2]) r_pc  <= cbus;
                if (cmask[3]) r_sp  <= cbus;
                if (cmask[4]) r_lv  <= cbus;
                if (cmask[5]) r_cpp <= cbus;
                if (cmask[6]) r_tos <= cbus;
                if (cmask[7]) r_opc <= cbus;
                if (cmask[8]) r_h   <= cbus;
                r_memctl <= cs_rdata[6:4];
                r_jam    <= cs_rdata[26:24];
                r_nxt    <= cs_rdata[35:27];
            end
            if (i_cmd.fetch_cap && r_memctl[0]) r_mbr <= m_rdata;
            if (i_cmd.rd_cap) r_mdr[8*i_cmd.cap_idx +: 8] <= m_rdata;
            if (i_cmd.npc) begin
                r_mpc <= (r_nxt | {((r_jam[0] & r_z) | (r_jam[1] & r_n)), 8'd0})
                         | (r_jam[2] ? {1'b0, mbr_now} : 9'd0);
            end
        end
    end

    assign o_micro_pc = r_mpc;
    assign o_mar = r_mar; assign o_mdr = r_mdr; assign o_pc = r_pc;
    assign o_sp = r_sp; assign o_lv = r_lv; assign o_cpp = r_cpp;
    assign o_tos = r_tos; assign o_opc = r_opc; assign o_h = r_h;
    assign o_mbr = r_mbr;
    assign o_flags = {r_n, r_z};
endmodule
`default_nettype wire

// ===== rtl/core/microprogrammed_datapath_step_core.sv =====
// Top level: microprogrammed stack-machine datapath step core.
// A load (or reserved op) goes straight to S_DONE, with o_done high; a microcycle first
// passes S_UIR, S_EXEC, S_FETCH, then S_RD0..S_RD3 and S_RDLAST for a word read, and
// S_WR0..S_WR3 for a word write, as the single-port byte memory serves the fetch and
// the four byte accesses in turn. busy drops the cycle after o_done, and no request is
// taken while busy. After reset a clearing pass zeroes the byte memory, one byte per
// cycle, with busy high. Results are shown for one cycle on o_done.
`default_nettype none
module microprogrammed_datapath_step_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_load_address,
    input  wire logic [35:0] i_load_data,
    output logic             o_done,
    output logic [8:0]       o_micro_pc,
    output logic [31:0]      o_mar_value,
    output logic [31:0]      o_mdr_value,
    output logic [31:0]      o_pc_value,
    output logic [7:0]       o_mbr_value,
    output logic [31:0]      o_sp_value,
    output logic [31:0]      o_lv_value,
    output logic [31:0]      o_cpp_value,
    output logic [31:0]      o_tos_value,
    output logic [31:0]      o_opc_value,
    output logic [31:0]      o_h_value,
    output logic [1:0]       o_flag_bits
);
    import mdsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mdsc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_opcode(i_opcode),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy), .o_done(o_done)
    );

    mdsc_dp u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_load_address(i_load_address),
        .i_load_data(i_load_data), .o_stat(stat), .o_micro_pc(o_micro_pc),
        .o_mar(o_mar_value), .o_mdr(o_mdr_value), .o_pc(o_pc_value),
        .o_sp(o_sp_value), .o_lv(o_lv_value), .o_cpp(o_cpp_value),
        .o_tos(o_tos_value), .o_opc(o_opc_value), .o_h(o_h_value),
        .o_mbr(o_mbr_value), .o_flags(o_flag_bits)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_no_double_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result repeated");
endmodule
`default_nettype wire

// ===== bench/tb_microprogrammed_datapath_step_core.sv =====
// Testbench for the microprogrammed datapath step core: directed and random requests, scoreboard.
module tb_microprogrammed_datapath_step_core;
    import mdsc_pkg::*;

    localparam int R_MAR = 0;
    localparam int R_MDR = 1;
    localparam int R_PC  = 2;
    localparam int R_SP  = 3;
    localparam int R_LV  = 4;
    localparam int R_CPP = 5;
    localparam int R_TOS = 6;
    localparam int R_OPC = 7;
    localparam int R_H   = 8;
    localparam int NUM_REQUESTS = 1900;
    localparam int IDLE_LIMIT   = 200000;

    typedef struct {
        logic [8:0]  upc;
        logic [31:0] regs [9];
        logic [7:0]  mbr;
        logic [1:0]  flags;
    } t_snapshot;

    class datapath_scoreboard;
        logic [35:0] ustore [CsDepth];
        bit          ustore_valid [CsDepth];
        logic [7:0]  bytes [MemBytes];
        logic [31:0] regs [9];
        logic [7:0]  mbr;
        logic [8:0]  upc;
        logic        nflag;
        logic        zflag;
        t_snapshot   pending [$];
        int          mismatches;

        function void clear();
            foreach (ustore[k]) begin
                ustore[k] = '0;
                ustore_valid[k] = 0;
            end
            foreach (bytes[k]) bytes[k] = '0;
            foreach (regs[k]) regs[k] = '0;
            mbr = '0;
            upc = '0;
            nflag = 1'b0;
            zflag = 1'b1;
            mismatches = 0;
        endfunction

        function logic [31:0] bus_b(logic [3:0] sel);
            case (sel)
                B_MDR:   return regs[R_MDR];
                B_PC:    return regs[R_PC];
                B_MBRU:  return {24'd0, mbr};
                B_MBRS:  return {{24{mbr[7]}}, mbr};
                B_SP:    return regs[R_SP];
                B_LV:    return regs[R_LV];
                B_CPP:   return regs[R_CPP];
                B_TOS:   return regs[R_TOS];
                B_OPC:   return regs[R_OPC];
                default: return '0;
            endcase
        endfunction

        function void microcycle();
            logic [35:0] mi;
            logic [5:0]  fn;
            logic [31:0] x, y, aout, cval, word;
            logic [15:0] ba;
            logic [8:0]  nxt;
            mi = ustore[upc];
            fn = mi[21:16];
            x = fn[3] ? regs[R_H] : 32'd0;
            if (fn[1]) x = ~x;
            y = fn[2] ? bus_b(mi[3:0]) : 32'd0;
            case ({fn[5], fn[4]})
                2'b00:   aout = x & y;
                2'b01:   aout = x | y;
                2'b10:   aout = ~y;
                default: aout = x + y + {31'd0, fn[0]};
            endcase
            nflag = aout[31];
            zflag = (aout == 32'd0);
            cval = aout;
            if (mi[22]) cval = cval << 8;
            if (mi[23]) cval = {cval[31], cval[31:1]};
            for (int r = 0; r < 9; r++)
                if (mi[7 + r]) regs[r] = cval;
            if (mi[4]) mbr = bytes[regs[R_PC][15:0]];
            if (mi[5]) begin
                word = '0;
                for (int k = 0; k < 4; k++) begin
                    ba = {regs[R_MAR][13:0], 2'b00} + 16'(k);
                    word[8*k +: 8] = bytes[ba];
                end
                regs[R_MDR] = word;
            end
            if (mi[6])
                for (int k = 0; k < 4; k++) begin
                    ba = {regs[R_MAR][13:0], 2'b00} + 16'(k);
                    bytes[ba] = regs[R_MDR][8*k +: 8];
                end
            nxt = mi[35:27];
            if ((mi[24] && zflag) || (mi[25] && nflag)) nxt[8] = 1'b1;
            if (mi[26]) nxt = nxt | {1'b0, mbr};
            upc = nxt;
        endfunction

        function void note(logic [1:0] op, logic [15:0] addr, logic [35:0] data);
            t_snapshot s;
            case (op)
                OP_EXEC: microcycle();
                OP_MEMW: bytes[addr] = data[7:0];
                OP_CSW: begin
                    ustore[addr[8:0]] = data;
                    ustore_valid[addr[8:0]] = 1;
                end
                default: ;
            endcase
            s.upc = upc;
            s.regs = regs;
            s.mbr = mbr;
            s.flags = {nflag, zflag};
            pending.push_back(s);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", field, exp_v, act_v);
        endfunction

        function void check(t_snapshot got);
            string names [9] = '{"mar", "mdr", "pc", "sp", "lv", "cpp", "tos", "opc", "h"};
            t_snapshot want;
            if (pending.size() == 0) begin
                report("unexpected result", 32'd0, 32'(got.upc));
                return;
            end
            want = pending.pop_front();
            if (want.upc !== got.upc) report("micro_pc", 32'(want.upc), 32'(got.upc));
            for (int r = 0; r < 9; r++)
                if (want.regs[r] !== got.regs[r]) report(names[r], want.regs[r], got.regs[r]);
            if (want.mbr !== got.mbr) report("mbr", 32'(want.mbr), 32'(got.mbr));
            if (want.flags !== got.flags) report("flags", 32'(want.flags), 32'(got.flags));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_load_address = '0;
    logic [35:0] i_load_data = '0;
    logic        busy, o_done;
    logic [8:0]  o_micro_pc;
    logic [31:0] o_mar_value, o_mdr_value, o_pc_value, o_sp_value, o_lv_value;
    logic [31:0] o_cpp_value, o_tos_value, o_opc_value, o_h_value;
    logic [7:0]  o_mbr_value;
    logic [1:0]  o_flag_bits;

    datapath_scoreboard sb = new();
    int idle_cycles = 0;

    microprogrammed_datapath_step_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_load_address(i_load_address), .i_load_data(i_load_data),
        .o_done(o_done), .o_micro_pc(o_micro_pc), .o_mar_value(o_mar_value),
        .o_mdr_value(o_mdr_value), .o_pc_value(o_pc_value), .o_mbr_value(o_mbr_value),
        .o_sp_value(o_sp_value), .o_lv_value(o_lv_value), .o_cpp_value(o_cpp_value),
        .o_tos_value(o_tos_value), .o_opc_value(o_opc_value), .o_h_value(o_h_value),
        .o_flag_bits(o_flag_bits)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_snapshot got;
        if (o_done) begin
            got.upc = o_micro_pc;
            got.regs = '{o_mar_value, o_mdr_value, o_pc_value, o_sp_value, o_lv_value,
                         o_cpp_value, o_tos_value, o_opc_value, o_h_value};
            got.mbr = o_mbr_value;
            got.flags = o_flag_bits;
            sb.check(got);
        end
    end

    // watchdog: cycles with no request accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [15:0] addr, logic [35:0] data);
        @(negedge i_clk);
        start = 1'b1;
        i_opcode = op;
        i_load_address = addr;
        i_load_data = data;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note(op, addr, data);
    endtask

    task automatic pause(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic logic [35:0] uinstr(logic [3:0] b, logic [2:0] m, logic [8:0] c,
                                           logic [5:0] alu, logic [1:0] sh, logic [2:0] jam,
                                           logic [8:0] nxt);
        return {nxt, jam, sh, alu, c, m, b};
    endfunction

    function automatic logic [35:0] rand_uinstr();
        return {4'($urandom), $urandom};
    endfunction

    // place a microinstruction at the current micro-PC, then run it
    task automatic run_uinstr(logic [35:0] mi);
        send(OP_CSW, {7'($urandom), sb.upc}, mi);
        send(OP_EXEC, 16'($urandom), {4'($urandom), $urandom});
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int burst;
        int kind;
        sb.clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        send(OP_RSVD, 16'hFFFF, 36'hF_FFFF_FFFF);
        send(OP_MEMW, 16'h0000, 36'hF_FFFF_FF80);
        send(OP_MEMW, 16'hFFFF, 36'h0_0000_00A5);
        send(OP_MEMW, 16'h0001, 36'h0_0000_0012);
        send(OP_CSW, 16'hFFFF, 36'h0);
        // fetch MBR=0x80 from PC 0, sign-extend through ALU pass B
        run_uinstr(uinstr(B_MBRS, 3'b001, 9'h1FF, 6'b010100, 2'b00, 3'b000, 9'd5));
        run_uinstr(uinstr(B_MBRS, 3'b000, 9'h100, 6'b010100, 2'b11, 3'b010, 9'd7));
        // MAR = -1 (wraps), read then write same word
        run_uinstr(uinstr(B_MDR, 3'b110, 9'h001, 6'b110110, 2'b00, 3'b000, 9'd3));
        run_uinstr(uinstr(B_PC, 3'b011, 9'h004, 6'b111101, 2'b01, 3'b100, 9'h100));
        run_uinstr(uinstr(B_OPC, 3'b000, 9'h1FE, 6'b001100, 2'b00, 3'b001, 9'd0));
        run_uinstr(uinstr(4'd15, 3'b000, 9'h100, 6'b111100, 2'b10, 3'b111, 9'h1FF));
        run_uinstr(uinstr(B_TOS, 3'b111, 9'h0AA, 6'b011100, 2'b11, 3'b011, 9'd2));
        run_uinstr(uinstr(B_MBRU, 3'b001, 9'h155, 6'b101000, 2'b01, 3'b100, 9'd1));
        drain();

        // random
        for (int n = 0; n < NUM_REQUESTS; ) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++, n++) begin
                kind = $urandom_range(0, 99);
                if (!sb.ustore_valid[sb.upc] || kind < 10)
                    send(OP_CSW, {7'($urandom), sb.upc}, rand_uinstr());
                else if (kind < 70)
                    send(OP_EXEC, 16'($urandom), {4'($urandom), $urandom});
                else if (kind < 85)
                    send(OP_MEMW, ($urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                                        : 16'($urandom)),
                         {4'($urandom), $urandom});
                else if (kind < 93)
                    send(OP_CSW, 16'($urandom), rand_uinstr());
                else
                    send(OP_RSVD, 16'($urandom), {4'($urandom), $urandom});
            end
            if (n > NUM_REQUESTS / 2 && n - burst <= NUM_REQUESTS / 2) drain();
            else if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 12));
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/mdsc_pkg.sv
rtl/core/mdsc_ram.sv
rtl/core/mdsc_ctrl.sv
rtl/core/mdsc_dp.sv
rtl/core/microprogrammed_datapath_step_core.sv
bench/tb_microprogrammed_datapath_step_core.sv
